>>> design/ultrasonic_echo_ranger_core_macros.svh
// Shared assertion macros for the echo ranger.
// Each one samples on clk and is disabled while rst_n is low.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH

// Same-cycle implication.
`define UER_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/uer_pkg.sv
package uer_pkg;

  localparam int TRIG_W    = 8;
  localparam int ELAPSED_W = 22;
  localparam int DIST_W    = 14;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [DIST_W-1:0]    DIST_MAX    = '1;

  localparam logic [TRIG_W-1:0]    TRIGGER_RST = 8'd11;
  localparam logic [ELAPSED_W-1:0] TIMEOUT_RST = 22'd1500000;

  // Register index = paddr[2]
  localparam logic REG_TRIGGER = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_MEAS
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0]    trigger_ticks;
    logic [ELAPSED_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [DIST_W-1:0] distance_mm;
  } res_t;

endpackage

>>> design/uer_in_if.sv
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

>>> design/uer_out_if.sv
interface uer_out_if;
  logic                      valid;
  logic                      ready;
  logic                      trigger_level;
  logic                      busy_res;
  logic                      done_res;
  logic                      timed_out;
  logic [uer_pkg::DIST_W-1:0] distance_mm;

  modport source (output valid, output trigger_level, output busy_res, output done_res,
                  output timed_out, output distance_mm, input ready);
  modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                  input timed_out, input distance_mm, output ready);
endinterface

>>> design/uer_cfg.sv
module uer_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output uer_pkg::cfg_t              cfg
);

  uer_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks <= uer_pkg::TRIGGER_RST;
      cfg_r.timeout_ticks <= uer_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        uer_pkg::REG_TRIGGER: cfg_r.trigger_ticks <= pwdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_TIMEOUT: cfg_r.timeout_ticks <= pwdata[uer_pkg::ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      uer_pkg::REG_TRIGGER:
        prdata = {{(uer_pkg::DATA_W-uer_pkg::TRIG_W){1'b0}}, cfg_r.trigger_ticks};
      uer_pkg::REG_TIMEOUT:
        prdata = {{(uer_pkg::DATA_W-uer_pkg::ELAPSED_W){1'b0}}, cfg_r.timeout_ticks};
      default: prdata = '0;
    endcase
  end

endmodule

>>> design/uer_ctrl.sv
`include "ultrasonic_echo_ranger_core_macros.svh"

module uer_ctrl #(
  parameter int ECHO_WIDTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          start_req,
  input  logic          echo_level,
  input  uer_pkg::cfg_t cfg,
  output uer_pkg::res_t res
);

  localparam int EW = uer_pkg::ELAPSED_W;
  localparam int DW = uer_pkg::DIST_W;

  uer_pkg::phase_t      phase_r, phase_nxt;
  logic [EW-1:0]        elapsed_r, elapsed_nxt, elapsed_inc;
  logic [ECHO_WIDTH_BITS-1:0] width_r, width_nxt;
  // width mod 10, and (width/10)*17 mod 10; mm_r = floor(floor(width/10)*17/10)
  logic [3:0]           r10_r, r10_nxt;
  logic [3:0]           rem_r, rem_nxt;
  logic [DW-1:0]        mm_r, mm_nxt, mm_step;
  logic [DW:0]          mm_sum;
  logic                 prev_r;
  logic                 rise, fall;
  logic                 done, tmo;
  logic [DW-1:0]        mm_out;

  assign rise        = echo_level && !prev_r;
  assign fall        = !echo_level && prev_r;
  assign elapsed_inc = elapsed_r + EW'(elapsed_r != uer_pkg::ELAPSED_MAX);
  assign mm_sum      = {1'b0, mm_r} + ((rem_r >= 4'd3) ? (DW+1)'(2) : (DW+1)'(1));
  assign mm_step     = (mm_sum > {1'b0, uer_pkg::DIST_MAX}) ? uer_pkg::DIST_MAX
                                                             : mm_sum[DW-1:0];

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    width_nxt   = width_r;
    r10_nxt     = r10_r;
    rem_nxt     = rem_r;
    mm_nxt      = mm_r;
    done        = 1'b0;
    tmo         = 1'b0;
    mm_out      = '0;
    case (phase_r)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          phase_nxt   = uer_pkg::PH_TRIG;
          elapsed_nxt = EW'(1);
          width_nxt   = '0;
        end
      end
      uer_pkg::PH_TRIG: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > {{(EW-uer_pkg::TRIG_W){1'b0}}, cfg.trigger_ticks}) begin
          phase_nxt = uer_pkg::PH_WAIT;
        end
      end
      uer_pkg::PH_WAIT: begin
        elapsed_nxt = elapsed_inc;
        if (rise) begin
          phase_nxt = uer_pkg::PH_MEAS;
          width_nxt = ECHO_WIDTH_BITS'(1);
          r10_nxt   = 4'd1;
          rem_nxt   = 4'd0;
          mm_nxt    = '0;
        end
      end
      uer_pkg::PH_MEAS: begin
        elapsed_nxt = elapsed_inc;
        if (echo_level) begin
          if (width_r != {ECHO_WIDTH_BITS{1'b1}}) begin
            width_nxt = width_r + ECHO_WIDTH_BITS'(1);
            if (r10_r == 4'd9) begin
              // quotient steps: add 17 to the scaled value
              r10_nxt = 4'd0;
              rem_nxt = (rem_r >= 4'd3) ? rem_r - 4'd3 : rem_r + 4'd7;
              mm_nxt  = mm_step;
            end else begin
              r10_nxt = r10_r + 4'd1;
            end
          end
        end else if (fall) begin
          done      = 1'b1;
          mm_out    = mm_r;
          phase_nxt = uer_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = uer_pkg::PH_IDLE;
    endcase
    if (phase_r != uer_pkg::PH_IDLE && !done && elapsed_inc >= cfg.timeout_ticks) begin
      done      = 1'b1;
      tmo       = 1'b1;
      phase_nxt = uer_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= uer_pkg::PH_IDLE;
      elapsed_r <= '0;
      width_r   <= '0;
      r10_r     <= '0;
      rem_r     <= '0;
      mm_r      <= '0;
      prev_r    <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      width_r   <= width_nxt;
      r10_r     <= r10_nxt;
      rem_r     <= rem_nxt;
      mm_r      <= mm_nxt;
      prev_r    <= echo_level;
    end
  end

  assign res.trigger_level = (phase_nxt == uer_pkg::PH_TRIG);
  assign res.busy_res      = (phase_nxt != uer_pkg::PH_IDLE);
  assign res.done_res      = done;
  assign res.timed_out     = tmo;
  assign res.distance_mm   = mm_out;

  `UER_ASSERT_NOW(a_digit_range, 1'b1, r10_r < 4'd10 && rem_r < 4'd10, "decade digit out of range")
  `UER_ASSERT_NEXT(a_state_hold, !in_fire, $stable(phase_r) && $stable(elapsed_r), "state moved without a tick")
  `UER_ASSERT_NOW(a_done_idle, in_fire && done, !res.busy_res && !res.trigger_level, "done while still busy")

endmodule

>>> design/uer_skid.sv
`include "ultrasonic_echo_ranger_core_macros.svh"

module uer_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uer_pkg::res_t push_data,
  output logic          can_push,
  output logic          out_valid,
  input  logic          out_ready,
  output uer_pkg::res_t out_data
);

  logic          main_v_r, skid_v_r;
  uer_pkg::res_t main_d_r, skid_d_r;
  logic          main_free;

  assign can_push  = !skid_v_r;
  assign main_free = !main_v_r || out_ready;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (main_free) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

  `UER_ASSERT_NOW(a_skid_behind_main, skid_v_r, main_v_r, "skid entry without a head entry")
  `UER_ASSERT_NEXT(a_skid_drains, skid_v_r && out_ready, !skid_v_r, "skid entry not drained")

endmodule

>>> design/ultrasonic_echo_ranger_core.sv
// Output: the result of an accepted tick is registered into the output buffer and shown on out_ch from there.
// Throughput: one tick per cycle; in_ch.ready stays high unless the two-entry
//   output buffer is full, so it drops only after a stall of out_ch.ready.
// Reset: synchronous on rst_n low; idle phase, counters cleared, buffer empty,
//   trigger_ticks = 11 and timeout_ticks = 1500000.
module ultrasonic_echo_ranger_core #(
  parameter int ECHO_WIDTH_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  uer_in_if.sink                     in_ch,
  uer_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  // Register block; writes land at once and are seen by the next tick.
  uer_pkg::cfg_t cfg;
  uer_pkg::res_t res;
  uer_pkg::res_t out_data;
  logic          can_push;
  logic          in_fire;

  uer_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Every tick transaction is one step of the ranging sequencer.
  assign in_ch.ready = can_push;
  assign in_fire     = in_ch.valid && can_push;

  // Sequencer: phase, elapsed count, echo width and a running distance.
  // The distance is tracked with decade counters as the width grows, so no
  // divider sits on the result path.
  uer_ctrl #(
    .ECHO_WIDTH_BITS (ECHO_WIDTH_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .start_req  (in_ch.start_req),
    .echo_level (in_ch.echo_level),
    .cfg        (cfg),
    .res        (res)
  );

  // Output register plus skid entry: ready toward the input never depends
  // combinationally on out_ch.ready.
  uer_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.trigger_level = out_data.trigger_level;
  assign out_ch.busy_res      = out_data.busy_res;
  assign out_ch.done_res      = out_data.done_res;
  assign out_ch.timed_out     = out_data.timed_out;
  assign out_ch.distance_mm   = out_data.distance_mm;

endmodule
